// ===== sv/hs5_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hs5_pkg - shared types and constants for the 5-point heat stencil
// Word formats for the input and result channels, config register indexes
// and fixed-point limits.
// ----------------------------------------------------------------------------
package hs5_pkg;

    localparam int VALUE_W    = 48;
    localparam int HEAT_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GW_W       = 11;
    localparam int GH_W       = 16;
    localparam int EN_W       = 16;
    localparam int ROW_W      = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ENERGY = 2'd2;

    localparam logic [GW_W-1:0] GRID_WIDTH_RST    = 11'd64;
    localparam logic [GH_W-1:0] GRID_HEIGHT_RST   = 16'd64;
    localparam logic [EN_W-1:0] SOURCE_ENERGY_RST = 16'd1;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [HEAT_W-1:0]  HEAT_MAX  = {1'b0, {(HEAT_W-1){1'b1}}};
    localparam logic signed [HEAT_W-1:0]  HEAT_MIN  = {1'b1, {(HEAT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] cell_value;
        logic [1:0]                source_count;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] new_value;
        logic signed [HEAT_W-1:0]  heat_total;
        logic                      last_cell;
    } out_word_t;

    // one line-buffer entry: row directly above and row two above
    typedef struct packed {
        logic signed [VALUE_W-1:0] row_a;
        logic signed [VALUE_W-1:0] row_b;
    } line_entry_t;

endpackage

// ===== sv/hs5_line_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hs5_line_buf - two-row line buffer
// One entry per padded column holds the previous two rows. One write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module hs5_line_buf #(
    parameter int DEPTH = 1026
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  hs5_pkg::line_entry_t             wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output hs5_pkg::line_entry_t             rd_data
);
    import hs5_pkg::*;

    line_entry_t mem [DEPTH];
    line_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/hs5_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hs5_cell - one stencil window cell
// Holds one neighbor value and passes it on when the window shifts.
// ----------------------------------------------------------------------------
module hs5_cell (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  shift_en,
    input  logic signed [hs5_pkg::VALUE_W-1:0]    d_in,
    output logic signed [hs5_pkg::VALUE_W-1:0]    q_out
);
    import hs5_pkg::*;

    logic signed [VALUE_W-1:0] val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
        end else if (shift_en) begin
            val_reg <= d_in;
        end
    end

    assign q_out = val_reg;

endmodule

// ===== sv/heat_stencil_5point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_stencil_5point - one Jacobi sweep of a 5-point heat stencil
// Padded grid cells stream in row-major order; each interior cell yields
// center/2 + (N+S+E+W)/8 plus a saturating running heat total.
// ----------------------------------------------------------------------------
//  channel | ports                      | word
//  --------+----------------------------+------------------------------------
//  in      | s_valid s_ready s_word     | cell_value, source_count
//  out     | m_valid m_ready m_word     | new_value, heat_total, last_cell
//  config  | cfg_we cfg_index cfg_wdata | grid_width, grid_height, energy
//
// One word per cycle sustained unless the output stalls. The stencil sum is
// registered in the middle stage, the heat accumulate in the output register.
// The line buffer read for the next column is issued the cycle a word is
// taken. Halo words produce no result. A stalled output holds one result
// while one more word is taken into the middle stage. Reset is synchronous.
// ----------------------------------------------------------------------------
module heat_stencil_5point #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [hs5_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hs5_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  hs5_pkg::in_word_t                    s_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output hs5_pkg::out_word_t                   m_word
);
    import hs5_pkg::*;

    localparam int DEPTH = MAX_WIDTH + 2;
    localparam int COL_W = $clog2(DEPTH);

    // config
    logic [GW_W-1:0]        grid_width_reg;
    logic [GH_W-1:0]        grid_height_reg;
    logic signed [EN_W-1:0] source_energy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg    <= GRID_WIDTH_RST;
            grid_height_reg   <= GRID_HEIGHT_RST;
            source_energy_reg <= SOURCE_ENERGY_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:    grid_width_reg    <= cfg_wdata[GW_W-1:0];
                CFG_GRID_HEIGHT:   grid_height_reg   <= cfg_wdata[GH_W-1:0];
                CFG_SOURCE_ENERGY: source_energy_reg <= cfg_wdata[EN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [COL_W-1:0] w_eff, w_end;
    logic [ROW_W-1:0] h_end;

    always_comb begin
        if (grid_width_reg == '0) begin
            w_eff = COL_W'(1);
        end else if (32'(grid_width_reg) > MAX_WIDTH) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = COL_W'(grid_width_reg);
        end
        w_end = w_eff + COL_W'(1);
        h_end = (grid_height_reg == '0) ? ROW_W'(2) : ROW_W'(grid_height_reg) + ROW_W'(1);
    end

    // handshake
    logic v1_reg, m_valid_reg, out_free, accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !v1_reg || out_free;
    assign accept   = s_valid && s_ready;

    // position
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    always_comb begin
        if (col_reg >= w_end) begin
            col_next = '0;
            row_next = (row_reg >= h_end) ? '0 : row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // source injection with 48-bit saturation
    logic signed [18:0]        src_prod;
    logic signed [VALUE_W:0]   cur_wide;
    logic signed [VALUE_W-1:0] cur;

    always_comb begin
        src_prod = 19'($signed({1'b0, s_word.source_count})) * 19'(source_energy_reg);
        cur_wide = {s_word.cell_value[VALUE_W-1], s_word.cell_value}
                 + (VALUE_W+1)'($signed({src_prod, 16'b0}));
        if (cur_wide[VALUE_W] != cur_wide[VALUE_W-1]) begin
            cur = cur_wide[VALUE_W] ? VALUE_MIN : VALUE_MAX;
        end else begin
            cur = cur_wide[VALUE_W-1:0];
        end
    end

    // line buffer, read address runs one column ahead on each accepted word
    line_entry_t lb_rd, lb_wr;
    logic [COL_W-1:0] rd_addr;

    assign rd_addr     = !aresetn ? '0 : (accept ? col_next : col_reg);
    assign lb_wr.row_a = cur;
    assign lb_wr.row_b = lb_rd.row_a;

    hs5_line_buf #(
        .DEPTH (DEPTH)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (lb_wr),
        .rd_addr (rd_addr),
        .rd_data (lb_rd)
    );

    // window: north, center -> west chain, south
    logic signed [VALUE_W-1:0] north, center, west, south;

    hs5_cell u_cell_north (
        .aclk (aclk), .aresetn (aresetn), .shift_en (accept),
        .d_in (lb_rd.row_b), .q_out (north)
    );
    hs5_cell u_cell_center (
        .aclk (aclk), .aresetn (aresetn), .shift_en (accept),
        .d_in (lb_rd.row_a), .q_out (center)
    );
    hs5_cell u_cell_west (
        .aclk (aclk), .aresetn (aresetn), .shift_en (accept),
        .d_in (center), .q_out (west)
    );
    hs5_cell u_cell_south (
        .aclk (aclk), .aresetn (aresetn), .shift_en (accept),
        .d_in (cur), .q_out (south)
    );

    // stencil: floor((4c + n + w + e + s) / 8)
    localparam int SUM_W = VALUE_W + 3;

    logic signed [SUM_W-1:0]   st_sum;
    logic signed [VALUE_W-1:0] nv;
    logic                      interior, first_cell, last_cell;

    always_comb begin
        st_sum = SUM_W'($signed({center, 2'b00}))
               + SUM_W'(north) + SUM_W'(west) + SUM_W'(lb_rd.row_a) + SUM_W'(south);
        nv     = st_sum[SUM_W-1:3];
        interior   = (col_reg >= COL_W'(2)) && (row_reg >= ROW_W'(2))
                  && (col_reg <= w_end) && (row_reg <= h_end);
        first_cell = (col_reg == COL_W'(2)) && (row_reg == ROW_W'(2));
        last_cell  = (col_reg == w_end) && (row_reg == h_end);
    end

    logic signed [VALUE_W-1:0] nv1_reg;
    logic                      first1_reg, last1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (accept) begin
            v1_reg <= interior;
        end else if (out_free) begin
            v1_reg <= 1'b0;
        end
        if (accept) begin
            nv1_reg    <= nv;
            first1_reg <= first_cell;
            last1_reg  <= last_cell;
        end
    end

    // heat accumulate, saturating at 64 bits; the output register is the total
    logic signed [HEAT_W:0]    acc_wide;
    logic signed [HEAT_W-1:0]  heat_reg, heat_next, nv_ext;
    logic signed [VALUE_W-1:0] new_value_reg;
    logic                      last_out_reg;

    always_comb begin
        nv_ext   = HEAT_W'(nv1_reg);
        acc_wide = {heat_reg[HEAT_W-1], heat_reg} + {nv_ext[HEAT_W-1], nv_ext};
        if (first1_reg) begin
            heat_next = nv_ext;
        end else if (acc_wide[HEAT_W] != acc_wide[HEAT_W-1]) begin
            heat_next = acc_wide[HEAT_W] ? HEAT_MIN : HEAT_MAX;
        end else begin
            heat_next = acc_wide[HEAT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            heat_reg    <= '0;
        end else if (out_free) begin
            m_valid_reg <= v1_reg;
            if (v1_reg) begin
                heat_reg <= heat_next;
            end
        end
        if (out_free && v1_reg) begin
            new_value_reg <= nv1_reg;
            last_out_reg  <= last1_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_word.new_value  = new_value_reg;
    assign m_word.heat_total = heat_reg;
    assign m_word.last_cell  = last_out_reg;

endmodule
